[rtl/sliding_window_jitter_stats_unit_assert.svh]
// ----------------------------------------------------------------------------
// sliding window jitter statistics - assertion macros
// checks are compiled in unless SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_JITTER_STATS_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_JITTER_STATS_UNIT_ASSERT_SVH

`ifndef SYNTH
// clocked check, off while reset is held
`define SWJS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("swjs check failed");
// clocked check that also runs during reset
`define SWJS_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("swjs reset check failed");
`else
`define SWJS_ASSERT(label, prop)
`define SWJS_ASSERT_RST(label, prop)
`endif

`endif

[rtl/swjs_pkg.sv]
// ----------------------------------------------------------------------------
// swjs_pkg
// shared types and constants of the sliding window jitter statistics unit
// ----------------------------------------------------------------------------
package swjs_pkg;

    // width of the window length register write data
    localparam int CFG_W = 9;

    // input operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic update;
        logic scan_read;
        logic div_mean_start;
        logic div_lwj_start;
        logic cap_mean;
        logic cap_lwj;
        logic out_load;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic n_zero;
        logic m_zero;
        logic scan_last;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/swjs_ram.sv]
// ----------------------------------------------------------------------------
// swjs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module swjs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/swjs_div.sv]
// ----------------------------------------------------------------------------
// swjs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module swjs_div #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;
    logic [DIVISOR_W-1:0]  n_rem;

    // one shift and trial subtract
    always_comb begin
        w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_ge    = (w_shift >= {1'b0, r_dvs});
        n_rem   = w_ge ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= STEP_W'(DIVIDEND_W - 1);
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            r_quo  <= {r_quo[DIVIDEND_W-2:0], w_ge};
            r_rem  <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/swjs_dp.sv]
// ----------------------------------------------------------------------------
// swjs_dp
// datapath: history, jitter ring, window scan, shared divider, result register
// ----------------------------------------------------------------------------
module swjs_dp
    import swjs_pkg::*;
#(
    parameter int MAX_WINDOW   = 256,
    parameter int LATENCY_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_dp_cmd                            i_cmd,
    output t_dp_sts                            o_sts,
    input  logic                               i_op,
    input  logic [LATENCY_BITS-1:0]            i_latency_us,
    input  logic                               i_cfg_we,
    input  logic [CFG_W-1:0]                   i_cfg_data,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic [LATENCY_BITS-1:0]            o_current_jitter,
    output logic [LATENCY_BITS-1:0]            o_min_jitter,
    output logic [LATENCY_BITS-1:0]            o_max_jitter,
    output logic [LATENCY_BITS-1:0]            o_mean_jitter,
    output logic [LATENCY_BITS-1:0]            o_latency_window_jitter,
    output logic [$clog2(MAX_WINDOW+1)-1:0]    o_jitter_count
);

    localparam int AW      = $clog2(MAX_WINDOW);
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = LATENCY_BITS + AW;
    localparam int RST_WIN = (MAX_WINDOW < 64) ? MAX_WINDOW : 64;

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WINDOW - 1);

    // item and history
    logic                    r_op;
    logic [LATENCY_BITS-1:0] r_lat;
    logic [CNT_W-1:0]        r_window;
    logic [AW-1:0]           r_wp;
    logic [CNT_W-1:0]        r_jfill;
    logic [CNT_W-1:0]        r_lfill;
    logic [LATENCY_BITS-1:0] r_prev;
    logic                    r_have_prev;

    // scan
    logic [AW-1:0]           r_rd_addr;
    logic [AW-1:0]           r_k;
    logic                    r_rd_vld;
    logic [AW-1:0]           r_rd_k;
    logic [SUM_W-1:0]        r_sum;
    logic [SUM_W-1:0]        r_sum_m;
    logic [LATENCY_BITS-1:0] r_cur;
    logic [LATENCY_BITS-1:0] r_min;
    logic [LATENCY_BITS-1:0] r_max;
    logic [LATENCY_BITS-1:0] r_mean;
    logic [LATENCY_BITS-1:0] r_lwj;

    // result register
    logic                    r_out_valid;
    logic [LATENCY_BITS-1:0] r_out_cur;
    logic [LATENCY_BITS-1:0] r_out_min;
    logic [LATENCY_BITS-1:0] r_out_max;
    logic [LATENCY_BITS-1:0] r_out_mean;
    logic [LATENCY_BITS-1:0] r_out_lwj;
    logic [CNT_W-1:0]        r_out_cnt;

    logic [CNT_W-1:0]        w_cfg_win;
    logic [LATENCY_BITS-1:0] w_jit;
    logic [AW-1:0]           w_wp_inc;
    logic [AW-1:0]           w_wp_new;
    logic [AW-1:0]           w_rd_init;
    logic [CNT_W-1:0]        w_lfill_m1;
    logic [CNT_W-1:0]        w_m;
    logic                    w_ring_we;
    logic [LATENCY_BITS-1:0] w_rdata;
    logic                    w_div_start;
    logic [SUM_W-1:0]        w_div_dividend;
    logic [CNT_W-1:0]        w_div_divisor;
    logic                    w_div_done;
    logic [SUM_W-1:0]        w_div_quo;

    // clamp of the written window length
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_win = CNT_W'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_WINDOW)) begin
            w_cfg_win = CNT_W'(MAX_WINDOW);
        end else begin
            w_cfg_win = CNT_W'(i_cfg_data);
        end
    end

    // new jitter and ring pointer arithmetic
    always_comb begin
        w_jit     = (r_lat >= r_prev) ? (r_lat - r_prev) : (r_prev - r_lat);
        w_wp_inc  = (r_wp == LAST_ADDR) ? '0 : (r_wp + 1'b1);
        w_wp_new  = r_have_prev ? w_wp_inc : r_wp;
        w_rd_init = (w_wp_new == '0) ? LAST_ADDR : (w_wp_new - 1'b1);
        w_ring_we = i_cmd.update && (r_op == OP_SAMPLE) && r_have_prev;
    end

    // jitters covered by the latency window
    always_comb begin
        w_lfill_m1 = r_lfill - CNT_W'(1);
        if (r_lfill < CNT_W'(2)) begin
            w_m = '0;
        end else if (w_lfill_m1 > r_jfill) begin
            w_m = r_jfill;
        end else begin
            w_m = w_lfill_m1;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_lat <= i_latency_us;
        end
    end

    // window register, fills and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= CNT_W'(RST_WIN);
            r_wp        <= '0;
            r_jfill     <= '0;
            r_lfill     <= '0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
        end else if (i_cmd.update) begin
            if (r_op == OP_CLEAR) begin
                r_wp        <= '0;
                r_jfill     <= '0;
                r_lfill     <= '0;
                r_prev      <= '0;
                r_have_prev <= 1'b0;
            end else begin
                if (r_lfill < r_window) begin
                    r_lfill <= r_lfill + 1'b1;
                end
                if (r_have_prev && (r_jfill < r_window)) begin
                    r_jfill <= r_jfill + 1'b1;
                end
                r_wp        <= w_wp_new;
                r_prev      <= r_lat;
                r_have_prev <= 1'b1;
            end
        end else if (i_cfg_we) begin
            r_window <= w_cfg_win;
            if (r_jfill > w_cfg_win) begin
                r_jfill <= w_cfg_win;
            end
            if (r_lfill > w_cfg_win) begin
                r_lfill <= w_cfg_win;
            end
        end
    end

    // jitter ring
    swjs_ram #(
        .WIDTH (LATENCY_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ring_we),
        .i_waddr (r_wp),
        .i_wdata (w_jit),
        .i_re    (i_cmd.scan_read),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    // read data valid in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_read;
        end
    end

    // scan from the newest entry backwards, accumulate sums, min and max
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_rd_addr <= w_rd_init;
            r_k       <= '0;
            r_sum     <= '0;
            r_sum_m   <= '0;
            r_cur     <= '0;
            r_min     <= '0;
            r_max     <= '0;
            r_mean    <= '0;
            r_lwj     <= '0;
        end else begin
            if (i_cmd.scan_read) begin
                r_rd_addr <= (r_rd_addr == '0) ? LAST_ADDR : (r_rd_addr - 1'b1);
                r_k       <= r_k + 1'b1;
                r_rd_k    <= r_k;
            end
            if (r_rd_vld) begin
                r_sum <= r_sum + SUM_W'(w_rdata);
                if (CNT_W'(r_rd_k) < w_m) begin
                    r_sum_m <= r_sum_m + SUM_W'(w_rdata);
                end
                if (r_rd_k == '0) begin
                    r_cur <= w_rdata;
                    r_min <= w_rdata;
                    r_max <= w_rdata;
                end else begin
                    if (w_rdata < r_min) begin
                        r_min <= w_rdata;
                    end
                    if (w_rdata > r_max) begin
                        r_max <= w_rdata;
                    end
                end
            end
            if (i_cmd.cap_mean) begin
                r_mean <= w_div_quo[LATENCY_BITS-1:0];
            end
            if (i_cmd.cap_lwj) begin
                r_lwj <= w_div_quo[LATENCY_BITS-1:0];
            end
        end
    end

    // shared divider for both means
    always_comb begin
        w_div_start    = i_cmd.div_mean_start || i_cmd.div_lwj_start;
        w_div_dividend = i_cmd.div_lwj_start ? r_sum_m : r_sum;
        w_div_divisor  = i_cmd.div_lwj_start ? w_m : r_jfill;
    end

    swjs_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_cur  <= r_cur;
            r_out_min  <= r_min;
            r_out_max  <= r_max;
            r_out_mean <= r_mean;
            r_out_lwj  <= r_lwj;
            r_out_cnt  <= r_jfill;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.n_zero    = (r_jfill == '0);
        o_sts.m_zero    = (w_m == '0);
        o_sts.scan_last = (CNT_W'(r_k) == (r_jfill - CNT_W'(1)));
        o_sts.div_done  = w_div_done;
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid             = r_out_valid;
    assign o_current_jitter        = r_out_cur;
    assign o_min_jitter            = r_out_min;
    assign o_max_jitter            = r_out_max;
    assign o_mean_jitter           = r_out_mean;
    assign o_latency_window_jitter = r_out_lwj;
    assign o_jitter_count          = r_out_cnt;

endmodule

[rtl/swjs_ctrl.sv]
// ----------------------------------------------------------------------------
// swjs_ctrl
// controller: sequences update, window scan, up to two divisions and result hand-off
// ----------------------------------------------------------------------------
module swjs_ctrl
    import swjs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UPDATE = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DRAIN  = 4'd3;
    localparam logic [3:0] S_MGO    = 4'd4;
    localparam logic [3:0] S_MWAIT  = 4'd5;
    localparam logic [3:0] S_LGO    = 4'd6;
    localparam logic [3:0] S_LWAIT  = 4'd7;
    localparam logic [3:0] S_RESULT = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.n_zero) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.scan_read = 1'b1;
                    if (i_sts.scan_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_MGO;
            end
            S_MGO: begin
                o_cmd.div_mean_start = 1'b1;
                n_state              = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_mean = 1'b1;
                    n_state        = i_sts.m_zero ? S_RESULT : S_LGO;
                end
            end
            S_LGO: begin
                o_cmd.div_lwj_start = 1'b1;
                n_state             = S_LWAIT;
            end
            S_LWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_lwj = 1'b1;
                    n_state       = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[rtl/sliding_window_jitter_stats_unit.sv]
// sequence: accept, update, scan of the n jitter entries in the window, drain, division
//   for the mean, division for the latency window mean, result; an empty window skips
//   scan and divisions, and the second division is skipped when the latency window is short
// one transaction at a time: the input stays stalled until the result is loaded, also over
//   output stalls; the ring read port scan and the shared one-bit-per-cycle divider set the pace
// reset: synchronous, windows empty, window length 64 (MAX_WINDOW if smaller), ring contents not cleared
// ----------------------------------------------------------------------------
// sliding_window_jitter_stats_unit
// delay jitter statistics over a sliding window of latency samples
// ----------------------------------------------------------------------------
module sliding_window_jitter_stats_unit
    import swjs_pkg::*;
#(
    parameter int MAX_WINDOW   = 256,
    parameter int LATENCY_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic [LATENCY_BITS-1:0]         i_latency_us,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [LATENCY_BITS-1:0]         o_current_jitter,
    output logic [LATENCY_BITS-1:0]         o_min_jitter,
    output logic [LATENCY_BITS-1:0]         o_max_jitter,
    output logic [LATENCY_BITS-1:0]         o_mean_jitter,
    output logic [LATENCY_BITS-1:0]         o_latency_window_jitter,
    output logic [$clog2(MAX_WINDOW+1)-1:0] o_jitter_count,
    // window length register
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [CFG_W-1:0]                i_cfg_window_length
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_cfg_we;

    // register writes are taken only between transactions
    assign o_cfg_ready = !o_in_stall;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // controller
    swjs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath
    swjs_dp #(
        .MAX_WINDOW   (MAX_WINDOW),
        .LATENCY_BITS (LATENCY_BITS)
    ) u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (w_cmd),
        .o_sts                   (w_sts),
        .i_op                    (i_op),
        .i_latency_us            (i_latency_us),
        .i_cfg_we                (w_cfg_we),
        .i_cfg_data              (i_cfg_window_length),
        .i_out_stall             (i_out_stall),
        .o_out_valid             (o_out_valid),
        .o_current_jitter        (o_current_jitter),
        .o_min_jitter            (o_min_jitter),
        .o_max_jitter            (o_max_jitter),
        .o_mean_jitter           (o_mean_jitter),
        .o_latency_window_jitter (o_latency_window_jitter),
        .o_jitter_count          (o_jitter_count)
    );

    // checks
`include "sliding_window_jitter_stats_unit_assert.svh"

    // an accepted transaction keeps the input stalled while it is worked on
    `SWJS_ASSERT(a_busy_after_accept, (i_in_valid && !o_in_stall) |=> o_in_stall)
    // window extremes stay ordered
    `SWJS_ASSERT(a_min_le_max, o_out_valid |-> (o_min_jitter <= o_max_jitter))
    // mean lies between the extremes
    `SWJS_ASSERT(a_mean_ge_min, o_out_valid |-> (o_mean_jitter >= o_min_jitter))
    `SWJS_ASSERT(a_mean_le_max, o_out_valid |-> (o_mean_jitter <= o_max_jitter))
    // reset empties the result register and frees the input
    `SWJS_ASSERT_RST(a_reset_idle, !i_rst_n |=> (!o_out_valid && !o_in_stall))

endmodule
